/* src/ubx_frame_receiver_top_assert.svh */
// Assertion macros shared by the frame receiver checker.
`ifndef UBX_FRAME_RECEIVER_TOP_ASSERT_SVH
`define UBX_FRAME_RECEIVER_TOP_ASSERT_SVH

// Clocked check, quiet while reset is asserted.
`define UBXFR_ASSERT_RUN(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define UBXFR_ASSERT_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ubxfr_pkg.sv */
// Types, constants and codes shared by the frame receiver modules.
package ubxfr_pkg;

	localparam int MAX_FRAME_BYTES = 128;
	localparam int STORE_DEPTH     = 2 * MAX_FRAME_BYTES;
	localparam int ADDR_W          = $clog2(STORE_DEPTH);
	localparam int IDX_W           = $clog2(MAX_FRAME_BYTES);
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 4);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int BYTE_W      = 8;
	localparam int READ_IDX_W  = 7;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd2;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST   = 8'hB5;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST  = 8'h62;
	localparam logic [BYTE_W-1:0] FRAME_LENGTH_RST = 8'd96;

	typedef struct packed {
		logic                  command;
		logic [BYTE_W-1:0]     data_byte;
		logic [READ_IDX_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		logic              frame_good;
		logic [BYTE_W-1:0] read_data;
		logic              has_frame;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_RECV,
		OP_READ,
		OP_READ_ZERO
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [BYTE_W-1:0]     data_byte;
		logic [READ_IDX_W-1:0] read_index;
	} qent_t;

endpackage

/* src/ubxfr_front.sv */
// Front end: accept and classify request transfers into a short queue.
module ubxfr_front
	import ubxfr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,
	output logic  head_valid,
	input  logic  head_pop,
	output qent_t head
);

	qent_t             fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	qent_t             cls;

	assign req_stall  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = fifo_q[rd_ptr_q];
	assign push       = req_valid && !req_stall;
	assign pop        = head_valid && head_pop;

	// classify: a read past the bank returns zero without touching the store
	always_comb begin
		cls.data_byte  = req.data_byte;
		cls.read_index = req.read_index;
		if (!req.command) begin
			cls.op = OP_RECV;
		end else if (32'(req.read_index) < MAX_FRAME_BYTES) begin
			cls.op = OP_READ;
		end else begin
			cls.op = OP_READ_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/ubxfr_back.sv */
// Back end: frame parser, checksum, banked frame store and result register.
module ubxfr_back
	import ubxfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 head_valid,
	output logic                 head_pop,
	input  qent_t                head,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic [BYTE_W-1:0] frame_length_q;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_a_q;
	logic [BYTE_W-1:0] sum_b_q;
	logic              rbank_q;
	logic              seen_q;

	logic [BYTE_W-1:0] store_q [STORE_DEPTH];

	logic              valid_s2;
	logic              good_s2;
	logic              rd_en_s2;
	logic              seen_s2;
	logic [BYTE_W-1:0] rdata_s2;

	logic              advance;
	logic              take;
	logic              recv;
	logic [POS_W-1:0]  eff_len;
	logic [POS_W:0]    body_end;
	logic [POS_W-1:0]  pos_d;
	logic [BYTE_W-1:0] sum_a_d;
	logic [BYTE_W-1:0] sum_b_d;
	logic              rbank_d;
	logic              seen_d;
	logic              good_d;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_k;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] byte_sum_a;

	assign advance  = !valid_s2 || !rsp_stall;
	assign head_pop = advance;
	assign take     = head_valid && advance;
	assign recv     = (head.op == OP_RECV);

	// clamp length to 1..MAX_FRAME_BYTES
	always_comb begin
		priority if (frame_length_q == '0) begin
			eff_len = POS_W'(1);
		end else if (32'(frame_length_q) > MAX_FRAME_BYTES) begin
			eff_len = POS_W'(MAX_FRAME_BYTES);
		end else begin
			eff_len = POS_W'(frame_length_q);
		end
	end

	assign body_end   = {1'b0, eff_len} + (POS_W+1)'(2);
	assign byte_sum_a = sum_a_q + head.data_byte;
	assign wr_k       = IDX_W'(pos_q - POS_W'(2));
	assign wr_addr    = rbank_q ? ADDR_W'(wr_k) : ADDR_W'(MAX_FRAME_BYTES) + ADDR_W'(wr_k);
	assign rd_addr    = rbank_q ? ADDR_W'(MAX_FRAME_BYTES) + ADDR_W'(head.read_index)
	                            : ADDR_W'(head.read_index);

	// parser next state
	always_comb begin
		pos_d   = pos_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		rbank_d = rbank_q;
		seen_d  = seen_q;
		good_d  = 1'b0;
		wr_en   = 1'b0;
		if (recv) begin
			priority if (pos_q == '0) begin
				if (head.data_byte == sync_first_q) begin
					pos_d = POS_W'(1);
				end
			end else if (pos_q == POS_W'(1)) begin
				if (head.data_byte == sync_second_q) begin
					pos_d   = POS_W'(2);
					sum_a_d = '0;
					sum_b_d = '0;
				end else begin
					pos_d = '0;
				end
			end else if ({1'b0, pos_q} < body_end) begin
				wr_en   = 1'b1;
				sum_a_d = byte_sum_a;
				sum_b_d = sum_b_q + byte_sum_a;
				pos_d   = pos_q + 1'b1;
			end else if ({1'b0, pos_q} == body_end) begin
				pos_d = (head.data_byte == sum_a_q) ? pos_q + 1'b1 : '0;
			end else begin
				pos_d = '0;
				if ({1'b0, pos_q} == body_end + 1'b1 && head.data_byte == sum_b_q) begin
					rbank_d = !rbank_q;
					seen_d  = 1'b1;
					good_d  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q   <= SYNC_FIRST_RST;
			sync_second_q  <= SYNC_SECOND_RST;
			frame_length_q <= FRAME_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:   sync_first_q   <= cfg_data;
				REG_SYNC_SECOND:  sync_second_q  <= cfg_data;
				REG_FRAME_LENGTH: frame_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			rbank_q  <= 1'b0;
			seen_q   <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= head_valid;
			if (head_valid) begin
				pos_q   <= pos_d;
				sum_a_q <= sum_a_d;
				sum_b_q <= sum_b_d;
				rbank_q <= rbank_d;
				seen_q  <= seen_d;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			good_s2  <= good_d;
			rd_en_s2 <= (head.op == OP_READ);
			seen_s2  <= seen_d;
		end
	end

	// frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			store_q[wr_addr] <= head.data_byte;
		end
		if (take && head.op == OP_READ) begin
			rdata_s2 <= store_q[rd_addr];
		end
	end

	assign rsp_valid      = valid_s2;
	assign rsp.frame_good = good_s2;
	assign rsp.read_data  = rd_en_s2 ? rdata_s2 : '0;
	assign rsp.has_frame  = seen_s2;

endmodule

/* src/ubx_frame_receiver_top.sv */
// Top level of the serial frame receiver with Fletcher checksum.
// A request passes through the queue entry and then the result register before its response appears.
// Throughput: one request per cycle, receive or read, while rsp_stall does not hold the back end.
// The two-entry queue keeps taking requests, until full, while a response waits on rsp_stall.
// Reset clears the queue, parser, checksums, bank select and frame flag at once;
// the frame store itself is not cleared and holds garbage until written.
module ubx_frame_receiver_top
	import ubxfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	// request channel: receive a byte or read a stored frame byte
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	// response channel: one response per request
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	// queue head handed from the front end to the back end
	logic  head_valid;
	logic  head_pop;
	qent_t head;

	// Front end: classify each transfer (receive, read, read past the bank)
	// and hold it in the queue until the back end is free.
	ubxfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head       (head)
	);

	// Back end: advance the sync/body/checksum parser, write body bytes into
	// the receive bank, swap banks on a good checksum and register the
	// response. Reads see the bank as left by all earlier requests.
	ubxfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head       (head),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

/* src/ubxfr_checker.sv */
// Port-level checker for the frame receiver, bound to the top level.
`include "ubx_frame_receiver_top_assert.svh"

module ubxfr_checker
	import ubxfr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic rsp_held;
	logic rsp_good;
	logic frame_taken;
	logic port_idle;

	assign rsp_held    = rsp_valid && rsp_stall;
	assign rsp_good    = rsp_valid && rsp.frame_good;
	assign frame_taken = rsp_valid && !rsp_stall && rsp.has_frame;
	assign port_idle   = !rsp_valid && !req_stall;

	// the reset check applies only where $past(!arst_n) also holds
	`UBXFR_ASSERT_RUN(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp), "stalled rsp changed")
	`UBXFR_ASSERT_RUN(a_good_has, rsp_good |-> rsp.has_frame, "frame_good without has_frame")
	`UBXFR_ASSERT_RUN(a_good_zero, rsp_good |-> rsp.read_data == '0, "read data on receive")
	`UBXFR_ASSERT_RUN(a_has_sticky, frame_taken |=> !rsp_valid || rsp.has_frame, "has_frame fell")
	`UBXFR_ASSERT_ALL(a_reset_idle, !arst_n && $past(!arst_n) |-> port_idle, "busy in reset")

endmodule

bind ubx_frame_receiver_top ubxfr_checker u_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the serial frame receiver: sync hunt, Fletcher check, bank reads.
module tb_top;
	import ubxfr_pkg::*;

	// Request command codes
	localparam logic CMD_RECEIVE = 1'b0;
	localparam logic CMD_READ    = 1'b1;

	// Cycles with no transfer on either channel before the run is abandoned
	localparam int unsigned IDLE_LIMIT = 2000;

	// Ways a generated frame may be spoilt
	typedef enum int {
		FLAW_NONE,
		FLAW_SUM_A,
		FLAW_SUM_B,
		FLAW_SYNC,
		FLAW_SHORT
	} frame_flaw_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;

	// Mirror of the receiver: configuration, parser, Fletcher pair and both banks
	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [7:0]  frame_length_q;
	int unsigned parse_pos;
	logic [7:0]  fletch_a;
	logic [7:0]  fletch_b;
	logic [7:0]  bank_bytes [2*MAX_FRAME_BYTES];
	bit          bank_written [2*MAX_FRAME_BYTES];
	logic        readable;
	logic        frame_seen;

	// Responses still owed by the receiver, oldest first
	rsp_t        pending_rsp [$];
	int unsigned mismatches;

	// Sender burst state and running Fletcher pair of the frame being generated
	int unsigned burst_left;
	int unsigned items_sent;
	logic [7:0]  gen_sum_a;
	logic [7:0]  gen_sum_b;

	// Receiver stall pattern
	int unsigned stall_mode;
	int unsigned stall_left;
	int unsigned idle_cycles;

	ubx_frame_receiver_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Body length in force: zero counts as one, anything above a bank saturates
	function automatic int unsigned frame_len_now();
		if (frame_length_q == 8'd0)
			return 1;
		if (frame_length_q > MAX_FRAME_BYTES)
			return MAX_FRAME_BYTES;
		return frame_length_q;
	endfunction

	// Advance the mirror by one accepted request and return the response it owes
	function automatic rsp_t predict_response(req_t item);
		rsp_t        r;
		int unsigned len;
		int unsigned k;
		logic [7:0]  bv;
		r   = '0;
		len = frame_len_now();
		bv  = item.data_byte;
		if (item.command == CMD_READ) begin
			r.read_data = bank_bytes[{readable, item.read_index}];
		end else if (parse_pos == 0) begin
			if (bv == sync_first_q)
				parse_pos = 1;
		end else if (parse_pos == 1) begin
			// a miss here drops straight back to hunting; the byte is not retried
			if (bv == sync_second_q) begin
				parse_pos = 2;
				fletch_a  = 8'd0;
				fletch_b  = 8'd0;
			end else begin
				parse_pos = 0;
			end
		end else begin
			k = parse_pos - 2;
			if (k < len) begin
				// body bytes land in the bank that is not being read
				bank_bytes[{~readable, k[6:0]}]   = bv;
				bank_written[{~readable, k[6:0]}] = 1'b1;
				fletch_a  = fletch_a + bv;
				fletch_b  = fletch_b + fletch_a;
				parse_pos = parse_pos + 1;
			end else if (k == len) begin
				parse_pos = (bv == fletch_a) ? parse_pos + 1 : 0;
			end else begin
				// checksum B slot, or past it after the length shrank
				parse_pos = 0;
				if (k == len + 1 && bv == fletch_b) begin
					readable     = ~readable;
					frame_seen   = 1'b1;
					r.frame_good = 1'b1;
				end
			end
		end
		r.has_frame = frame_seen;
		return r;
	endfunction

	// Pick a read offset that the readable bank has held since some good frame
	function automatic logic [6:0] pick_read_index();
		logic [6:0]  idx;
		int unsigned tries;
		idx   = 7'($urandom);
		tries = 0;
		while (!bank_written[{readable, idx}] && tries < 64) begin
			idx   = 7'($urandom);
			tries = tries + 1;
		end
		// offset zero is always filled once a frame has been accepted
		if (!bank_written[{readable, idx}])
			idx = 7'd0;
		return idx;
	endfunction

	// Present one request in burst/gap fashion, hold it until transferred, then predict
	task automatic send_item(input req_t item);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall);
		pending_rsp.push_back(predict_response(item));
		burst_left = burst_left - 1;
		items_sent = items_sent + 1;
	endtask

	task automatic send_byte(input logic [7:0] b);
		req_t item;
		item.command    = CMD_RECEIVE;
		item.data_byte  = b;
		item.read_index = 7'($urandom);
		send_item(item);
	endtask

	task automatic send_read(input logic [6:0] idx);
		req_t item;
		item.command    = CMD_READ;
		item.data_byte  = 8'($urandom);
		item.read_index = idx;
		send_item(item);
	endtask

	// Send body bytes, folding them into the generator's Fletcher pair
	task automatic send_body(input int unsigned n, input int unsigned read_pct);
		logic [7:0] bv;
		repeat (n) begin
			bv        = 8'($urandom);
			gen_sum_a = gen_sum_a + bv;
			gen_sum_b = gen_sum_b + gen_sum_a;
			send_byte(bv);
			if (frame_seen && $urandom_range(0, 99) < read_pct)
				send_read(pick_read_index());
		end
	endtask

	// Send a whole frame at the current length, optionally spoilt, reads mixed in
	task automatic send_frame(input frame_flaw_t flaw, input int unsigned read_pct);
		int unsigned len;
		// flush any half-parsed frame so that the sync pair is seen as such
		while (parse_pos != 0)
			send_byte(8'($urandom));
		len       = frame_len_now();
		gen_sum_a = 8'd0;
		gen_sum_b = 8'd0;
		send_byte(sync_first_q);
		if (flaw == FLAW_SYNC) begin
			send_byte(sync_second_q ^ 8'($urandom_range(1, 255)));
			return;
		end
		send_byte(sync_second_q);
		if (flaw == FLAW_SHORT) begin
			send_body($urandom_range(0, len - 1), read_pct);
			return;
		end
		send_body(len, read_pct);
		if (flaw == FLAW_SUM_A) begin
			send_byte(gen_sum_a ^ 8'($urandom_range(1, 255)));
			return;
		end
		send_byte(gen_sum_a);
		send_byte((flaw == FLAW_SUM_B) ? gen_sum_b ^ 8'($urandom_range(1, 255)) : gen_sum_b);
	endtask

	// Drop valid and hold off until every owed response has been transferred
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_SYNC_FIRST:   sync_first_q   = value;
			REG_SYNC_SECOND:  sync_second_q  = value;
			REG_FRAME_LENGTH: frame_length_q = value;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] len);
		wait_drained();
		write_reg(REG_SYNC_FIRST, s1);
		write_reg(REG_SYNC_SECOND, s2);
		write_reg(REG_FRAME_LENGTH, len);
	endtask

	// Sync misses, a checksum miss on a byte that looks like sync, and length zero
	task automatic test_sync_and_checksum();
		set_config(8'hFF, 8'h00, 8'd0);
		send_byte(8'hFF);
		send_byte(8'hFF);      // misses second sync; must not count as a new first sync
		send_byte(8'h00);      // hunting again, so ignored
		send_frame(FLAW_NONE, 0);
		send_read(7'd0);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h11);
		send_byte(8'hFF);      // wrong checksum A that equals the first sync byte
		send_byte(8'h00);      // so this is not taken as the second sync byte
		send_read(7'd0);       // previous good frame is still the readable one
	endtask

	// Length rewritten while a frame is in flight
	task automatic test_length_change();
		set_config(8'hB5, 8'h62, 8'd4);
		gen_sum_a = 8'd0;
		gen_sum_b = 8'd0;
		send_byte(sync_first_q);
		send_byte(sync_second_q);
		send_body(4, 0);
		// position is now past the checksum slots of a one-byte frame: next byte is dropped
		wait_drained();
		write_reg(REG_FRAME_LENGTH, 8'd1);
		send_byte(8'($urandom));
		wait_drained();
		write_reg(REG_FRAME_LENGTH, 8'd4);
		gen_sum_a = 8'd0;
		gen_sum_b = 8'd0;
		send_byte(sync_first_q);
		send_byte(sync_second_q);
		send_body(3, 0);
		// shrink to three: the next byte is checksum A of the shortened frame
		wait_drained();
		write_reg(REG_FRAME_LENGTH, 8'd3);
		send_byte(gen_sum_a);
		send_byte(gen_sum_b);
		send_read(7'd2);
	endtask

	// Full-bank frames: read every offset, then an oversized length that saturates
	task automatic test_largest_frames();
		set_config(8'hB5, 8'h62, 8'd128);
		send_frame(FLAW_NONE, 0);
		for (int i = 0; i < MAX_FRAME_BYTES; i++)
			send_read(7'(i));
		set_config(8'hC3, 8'h3C, 8'd255);
		send_frame(FLAW_SUM_B, 5);
		send_frame(FLAW_NONE, 5);
		repeat (20) send_read(pick_read_index());
	endtask

	// Mostly well-formed frames with random bodies, plus spoilt frames, reads and noise
	task automatic test_random_traffic(input logic [7:0] s1, input logic [7:0] s2,
			input logic [7:0] len, input int unsigned n);
		int unsigned first;
		int unsigned r;
		bit          paused;
		set_config(s1, s2, len);
		first  = items_sent;
		paused = 1'b0;
		while (items_sent - first < n) begin
			// once per phase, hold the sender until the receiver has caught up
			if (!paused && items_sent - first >= n / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_frame((r < 45) ? FLAW_NONE : frame_flaw_t'($urandom_range(1, 4)), 8);
			end else if (r < 85) begin
				if (frame_seen)
					send_read(pick_read_index());
				else
					send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 5))
					send_byte(($urandom_range(0, 3) == 0) ? sync_first_q : 8'($urandom));
			end
		end
	endtask

	// Receiver stalls: free-running stretches, random stalls and a fixed duty pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(8, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 2) == 0);
			default: rsp_stall <= (stall_left[2:0] >= 3'd5);
		endcase
	end

	// Check each response transfer against the oldest owed response
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (pending_rsp.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("%0t: unexpected response %p", $realtime, rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.frame_good !== want.frame_good || rsp.read_data !== want.read_data ||
						rsp.has_frame !== want.has_frame) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("%0t: frame_good %b/%b read_data %h/%h has_frame %b/%b (exp/got)",
							$realtime, want.frame_good, rsp.frame_good, want.read_data,
							rsp.read_data, want.has_frame, rsp.has_frame);
				end
			end
		end
	end

	// Watchdog: abandon the run when nothing has been transferred for too long
	always @(posedge clk) begin
		if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		req_valid      = 1'b0;
		req            = '0;
		sync_first_q   = SYNC_FIRST_RST;
		sync_second_q  = SYNC_SECOND_RST;
		frame_length_q = FRAME_LENGTH_RST;
		parse_pos      = 0;
		fletch_a       = 8'd0;
		fletch_b       = 8'd0;
		readable       = 1'b0;
		frame_seen     = 1'b0;
		mismatches     = 0;
		burst_left     = 0;
		items_sent     = 0;
		stall_mode     = 0;
		stall_left     = 0;
		idle_cycles    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sync_and_checksum();
		test_length_change();
		test_largest_frames();
		test_random_traffic(8'hB5, 8'h62, 8'd4, 100);
		test_random_traffic(8'h00, 8'hFF, 8'd1, 100);
		test_random_traffic(8'h5A, 8'h5A, 8'd3, 100);
		test_random_traffic(8'($urandom), 8'($urandom), 8'($urandom_range(1, 12)), 100);
		test_random_traffic(SYNC_FIRST_RST, SYNC_SECOND_RST, FRAME_LENGTH_RST, 220);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
